/* hw/rtl/pcg32_stream_bounded_draw_core_macros.svh */
// Assertion macros used by the checker of this block.
`ifndef PCG32_STREAM_BOUNDED_DRAW_CORE_MACROS_SVH
`define PCG32_STREAM_BOUNDED_DRAW_CORE_MACROS_SVH

// Implication that must hold in the same cycle as its trigger.
`define PCGSBD_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pcgsbd check failed");

// Implication that must hold in the cycle after its trigger.
`define PCGSBD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pcgsbd check failed");

`endif

/* hw/rtl/pcgsbd_pkg.sv */
`default_nettype none

package pcgsbd_pkg;

   // Item field widths.
   localparam int OPCODE_W    = 2;
   localparam int STREAM_W    = 4;
   localparam int BOUND_W     = 32;
   localparam int SEED_W      = 64;
   localparam int STATE_LOW_W = 52;
   localparam int DRAW_W      = 32;
   localparam int STATE_W     = 64;

   // One generator per value of the stream index.
   localparam int NUM_STREAMS = 2 ** STREAM_W;

   // Generator constants.
   localparam logic [STATE_W-1:0] LCG_MULT   = 64'h5851_F42D_4C95_7F2D;
   localparam logic [STATE_W-1:0] INIT_STATE = 64'h853C_49E6_748F_EA9B;
   localparam logic [STATE_W-1:0] INIT_INC   = 64'hDA3E_39CB_94B9_5BDB;
   localparam logic [31:0]        MULT_LO    = LCG_MULT[31:0];
   localparam logic [31:0]        MULT_HI    = LCG_MULT[63:32];

   typedef enum logic [OPCODE_W-1:0] {
      OP_RAW     = 2'd0,
      OP_BOUNDED = 2'd1,
      OP_RESEED  = 2'd2,
      OP_SET_LOW = 2'd3
   } op_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_LOAD,
      S_SEED2,
      S_THR,
      S_MUL0,
      S_MUL1,
      S_MUL2,
      S_MUL3,
      S_MOD,
      S_WRITE
   } fsm_state_type;

   // XSH-RR output permutation of the state before the step.
   function automatic logic [DRAW_W-1:0] xsh_rr(input logic [STATE_W-1:0] old);
      logic [STATE_W-1:0] mixed;
      logic [DRAW_W-1:0]  xs;
      logic [4:0]         rot;
      logic [5:0]         lrot;
      mixed = ((old >> 18) ^ old) >> 27;
      xs    = mixed[DRAW_W-1:0];
      rot   = old[63:59];
      lrot  = 6'd32 - {1'b0, rot};
      return (xs >> rot) | (xs << lrot);
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/pcg32_stream_bounded_draw_core.sv */
// Sixteen PCG32 streams held in two memories (state and increment), each with one write
// port and one read port, worked on one item at a time. An item is taken when start is high
// and busy is low; its result appears on the rsp_ ports for exactly one cycle with rsp_valid,
// and the receiver cannot stall it, so it must be captured in that cycle. A bounded draw
// whose span does not cover all 32-bit values repeats the generator step until a draw
// passes the rejection threshold. Each generator step uses one 32 x 32 multiplier in
// states S_MUL0 to S_MUL2, and such a bounded draw runs the one-bit-per-cycle remainder
// unit twice (threshold and final reduction). Entries not yet written read as the reset seed.
`default_nettype none

module pcg32_stream_bounded_draw_core (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   output logic                                      busy,
   input  logic [pcgsbd_pkg::OPCODE_W-1:0]           req_opcode,
   input  logic [pcgsbd_pkg::STREAM_W-1:0]           req_stream_index,
   input  logic signed [pcgsbd_pkg::BOUND_W-1:0]     req_lower_bound,
   input  logic signed [pcgsbd_pkg::BOUND_W-1:0]     req_upper_bound,
   input  logic [pcgsbd_pkg::SEED_W-1:0]             req_seed_value,
   input  logic [pcgsbd_pkg::STATE_LOW_W-1:0]        req_state_value,
   output logic                                      rsp_valid,
   output logic [pcgsbd_pkg::DRAW_W-1:0]             rsp_draw_value,
   output logic [pcgsbd_pkg::STATE_LOW_W-1:0]        rsp_state_low
);

   import pcgsbd_pkg::*;

   // Stream memories and their registered read data.
   logic [STATE_W-1:0] state_mem [NUM_STREAMS];
   logic [STATE_W-1:0] inc_mem   [NUM_STREAMS];
   logic [STATE_W-1:0] rd_state_ff;
   logic [STATE_W-1:0] rd_inc_ff;
   logic [NUM_STREAMS-1:0] valid_ff;

   fsm_state_type fsm_ff, fsm_in;

   // Captured item and working registers.
   op_type                   op_ff;
   logic [STREAM_W-1:0]      idx_ff;
   logic [SEED_W-1:0]        seed_ff;
   logic [STATE_LOW_W-1:0]   set_ff;
   logic [BOUND_W-1:0]       ulo_ff;
   logic [BOUND_W-1:0]       span_ff;
   logic                     full_ff;
   logic [STATE_W-1:0]       work_state_ff;
   logic [STATE_W-1:0]       work_inc_ff;
   logic [STATE_W-1:0]       prod_ff;
   logic [31:0]              cross_ff;
   logic [DRAW_W-1:0]        r_ff;
   logic [BOUND_W-1:0]       rem_ff;
   logic [BOUND_W-1:0]       num_ff;
   logic [4:0]               cnt_ff;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [DRAW_W-1:0]        rsp_draw_ff, rsp_draw_in;
   logic [STATE_LOW_W-1:0]   rsp_low_ff, rsp_low_in;

   logic accept;
   logic mem_we;
   logic bounded_loop;

   // Bound ordering and span, worked out from the ports as the item is taken.
   logic                 swap;
   logic [BOUND_W-1:0]   lo_u;
   logic [BOUND_W-1:0]   hi_u;
   logic [BOUND_W-1:0]   span_in;

   assign swap    = req_upper_bound < req_lower_bound;
   assign lo_u    = swap ? $unsigned(req_upper_bound) : $unsigned(req_lower_bound);
   assign hi_u    = swap ? $unsigned(req_lower_bound) : $unsigned(req_upper_bound);
   assign span_in = hi_u - lo_u + 32'd1;

   // Stream entry as seen through the valid bits.
   logic [STATE_W-1:0] cur_state;
   logic [STATE_W-1:0] cur_inc;

   assign cur_state = valid_ff[idx_ff] ? rd_state_ff : INIT_STATE;
   assign cur_inc   = valid_ff[idx_ff] ? rd_inc_ff   : INIT_INC;

   // Shared 32 x 32 multiplier; the step's low 64 bits are built from three products.
   logic [31:0]        mul_a;
   logic [31:0]        mul_b;
   logic [63:0]        mul_p;

   always_comb begin
      case (fsm_ff)
         S_MUL1: begin
            mul_a = work_state_ff[63:32];
            mul_b = MULT_LO;
         end
         S_MUL2: begin
            mul_a = work_state_ff[31:0];
            mul_b = MULT_HI;
         end
         default: begin
            mul_a = work_state_ff[31:0];
            mul_b = MULT_LO;
         end
      endcase
   end

   assign mul_p = {32'd0, mul_a} * {32'd0, mul_b};

   // One restoring remainder step per cycle.
   logic [32:0]        div_shift;
   logic               div_ge;
   logic [BOUND_W-1:0] div_rem;
   logic [32:0]        div_diff;

   assign div_shift = {rem_ff, num_ff[31]};
   assign div_diff  = div_shift - {1'b0, span_ff};
   assign div_ge    = div_shift >= {1'b0, span_ff};
   assign div_rem   = div_ge ? div_diff[31:0] : div_shift[31:0];

   // A bounded draw that needs rejection and reduction.
   assign bounded_loop = (op_ff == OP_BOUNDED) && !full_ff;

   // Next state.
   always_comb begin
      fsm_in = fsm_ff;
      case (fsm_ff)
         S_IDLE: begin
            if (start) fsm_in = S_LOAD;
         end
         S_LOAD: begin
            case (op_ff)
               OP_RESEED:  fsm_in = S_SEED2;
               OP_SET_LOW: fsm_in = S_WRITE;
               OP_BOUNDED: fsm_in = full_ff ? S_MUL0 : S_THR;
               default:    fsm_in = S_MUL0;
            endcase
         end
         S_SEED2: fsm_in = S_MUL0;
         S_THR: begin
            if (cnt_ff == 5'd0) fsm_in = S_MUL0;
         end
         S_MUL0: fsm_in = S_MUL1;
         S_MUL1: fsm_in = S_MUL2;
         S_MUL2: fsm_in = S_MUL3;
         S_MUL3: begin
            if (!bounded_loop) fsm_in = S_WRITE;
            else if (r_ff < rem_ff) fsm_in = S_MUL0;
            else fsm_in = S_MOD;
         end
         S_MOD: begin
            if (cnt_ff == 5'd0) fsm_in = S_WRITE;
         end
         S_WRITE: fsm_in = S_IDLE;
         default: fsm_in = S_IDLE;
      endcase
   end

   // Outputs of the sequencer.
   always_comb begin
      busy         = fsm_ff != S_IDLE;
      mem_we       = fsm_ff == S_WRITE;
      rsp_valid_in = fsm_ff == S_WRITE;
      rsp_low_in   = work_state_ff[STATE_LOW_W-1:0];
      case (op_ff)
         OP_RAW:     rsp_draw_in = r_ff;
         OP_BOUNDED: rsp_draw_in = full_ff ? r_ff : ulo_ff + rem_ff;
         default:    rsp_draw_in = '0;
      endcase
   end

   assign accept = start && !busy;

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         fsm_ff       <= S_IDLE;
         valid_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         fsm_ff       <= fsm_in;
         rsp_valid_ff <= rsp_valid_in;
         if (mem_we) valid_ff[idx_ff] <= 1'b1;
      end
   end

   // Stream memories: write back at the end of an item, read at the address on the port.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         state_mem[idx_ff] <= work_state_ff;
         inc_mem[idx_ff]   <= work_inc_ff;
      end
      rd_state_ff <= state_mem[req_stream_index];
      rd_inc_ff   <= inc_mem[req_stream_index];
   end

   // Result registers.
   always_ff @(posedge clock) begin
      if (rsp_valid_in) begin
         rsp_draw_ff <= rsp_draw_in;
         rsp_low_ff  <= rsp_low_in;
      end
   end

   // Datapath.
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff   <= op_type'(req_opcode);
         idx_ff  <= req_stream_index;
         seed_ff <= req_seed_value;
         set_ff  <= req_state_value;
         ulo_ff  <= lo_u;
         span_ff <= span_in;
         full_ff <= span_in == '0;
      end
      case (fsm_ff)
         S_LOAD: begin
            rem_ff <= '0;
            num_ff <= '0 - span_ff;
            cnt_ff <= 5'd31;
            case (op_ff)
               OP_RESEED: begin
                  work_inc_ff   <= {seed_ff[SEED_W-2:0], 1'b1};
                  work_state_ff <= seed_ff + INIT_STATE;
               end
               OP_SET_LOW: begin
                  work_inc_ff   <= cur_inc;
                  work_state_ff <= {cur_state[STATE_W-1:STATE_LOW_W], set_ff};
               end
               default: begin
                  work_inc_ff   <= cur_inc;
                  work_state_ff <= cur_state;
               end
            endcase
         end
         S_SEED2: begin
            // The first step from a zero state leaves just the increment.
            work_state_ff <= work_state_ff + work_inc_ff;
         end
         S_THR, S_MOD: begin
            rem_ff <= div_rem;
            num_ff <= {num_ff[BOUND_W-2:0], 1'b0};
            cnt_ff <= cnt_ff - 5'd1;
         end
         S_MUL0: begin
            prod_ff <= mul_p;
            r_ff    <= xsh_rr(work_state_ff);
         end
         S_MUL1: begin
            prod_ff  <= prod_ff + work_inc_ff;
            cross_ff <= mul_p[31:0];
         end
         S_MUL2: begin
            cross_ff <= cross_ff + mul_p[31:0];
         end
         S_MUL3: begin
            work_state_ff <= {prod_ff[63:32] + cross_ff, prod_ff[31:0]};
            // An accepted draw starts the final reduction; rem_ff still holds the threshold.
            if (bounded_loop && !(r_ff < rem_ff)) begin
               rem_ff <= '0;
               num_ff <= r_ff;
               cnt_ff <= 5'd31;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_draw_value = rsp_draw_ff;
   assign rsp_state_low  = rsp_low_ff;

endmodule

`default_nettype wire

/* hw/rtl/pcgsbd_checker.sv */
`default_nettype none

`include "pcg32_stream_bounded_draw_core_macros.svh"

module pcgsbd_checker (
   input  logic                                      clock,
   input  logic                                      reset,
   input  logic                                      start,
   input  logic                                      busy,
   input  logic [pcgsbd_pkg::OPCODE_W-1:0]           req_opcode,
   input  logic [pcgsbd_pkg::STATE_LOW_W-1:0]        req_state_value,
   input  logic                                      rsp_valid,
   input  logic [pcgsbd_pkg::DRAW_W-1:0]             rsp_draw_value,
   input  logic [pcgsbd_pkg::STATE_LOW_W-1:0]        rsp_state_low
);

   import pcgsbd_pkg::*;

   // A taken item keeps the block busy in the following cycle.
   `PCGSBD_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)

   // The result strobe lasts one cycle.
   `PCGSBD_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid, !rsp_valid)

   // A result is shown only once the block is free, and the block frees with a result.
   `PCGSBD_ASSERT_SAME(a_result_idle, clock, reset, rsp_valid, !busy)
   `PCGSBD_ASSERT_SAME(a_free_result, clock, reset, $fell(busy), rsp_valid)

   // Setting the low state bits reports them back, through S_LOAD, S_WRITE and the result registers, with a zero draw.
   `PCGSBD_ASSERT_SAME(a_set_low, clock, reset,
      start && !busy && req_opcode == OP_SET_LOW,
      ##3 (rsp_valid && rsp_draw_value == '0 && rsp_state_low == $past(req_state_value, 3)))

endmodule

bind pcg32_stream_bounded_draw_core pcgsbd_checker u_pcgsbd_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_opcode      (req_opcode),
   .req_state_value (req_state_value),
   .rsp_valid       (rsp_valid),
   .rsp_draw_value  (rsp_draw_value),
   .rsp_state_low   (rsp_state_low)
);

`default_nettype wire

/* dv/pcg32_stream_bounded_draw_core_tb.sv */
`timescale 1ns / 100ps

module pcg32_stream_bounded_draw_core_tb;
   import pcgsbd_pkg::*;

   localparam int N_RANDOM       = 600;
   localparam int N_PCG_STREAMS  = 16;
   localparam int WATCHDOG_LIMIT = 5000;
   localparam int DRAIN_CYCLES   = 300;

   localparam logic [63:0] PCG_MULTIPLIER = 64'd6364136223846793005;
   localparam logic [63:0] PCG_SEED_STATE = 64'h853c_49e6_748f_ea9b;
   localparam logic [63:0] PCG_SEED_INC   = 64'hda3e_39cb_94b9_5bdb;

   typedef struct packed {
      op_type       opcode;
      logic [3:0]   stream;
      logic [31:0]  lower;
      logic [31:0]  upper;
      logic [63:0]  seed;
      logic [51:0]  state_val;
   } draw_req_t;

   typedef struct packed {
      logic [31:0] draw;
      logic [51:0] state_low;
   } draw_rsp_t;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         start = 1'b0;
   logic         busy;
   op_type       req_opcode = OP_RAW;
   logic [3:0]   req_stream_index = '0;
   logic [31:0]  req_lower_bound = '0;
   logic [31:0]  req_upper_bound = '0;
   logic [63:0]  req_seed_value = '0;
   logic [51:0]  req_state_value = '0;
   logic         rsp_valid;
   logic [31:0]  rsp_draw_value;
   logic [51:0]  rsp_state_low;

   pcg32_stream_bounded_draw_core dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_opcode       (req_opcode),
      .req_stream_index (req_stream_index),
      .req_lower_bound  (req_lower_bound),
      .req_upper_bound  (req_upper_bound),
      .req_seed_value   (req_seed_value),
      .req_state_value  (req_state_value),
      .rsp_valid        (rsp_valid),
      .rsp_draw_value   (rsp_draw_value),
      .rsp_state_low    (rsp_state_low)
   );

   // Own copy of every generator, kept in step with the items accepted.
   logic [63:0] pcg_state [N_PCG_STREAMS];
   logic [63:0] pcg_inc   [N_PCG_STREAMS];

   draw_req_t pending_reqs[$];
   draw_rsp_t expected_draws[$];
   draw_req_t cur_req;

   int n_total = 0;
   int n_accepted = 0;
   int n_results = 0;
   int n_errors = 0;
   int op_count [4] = '{0, 0, 0, 0};
   int gap_left = 0;
   int burst_left = 0;
   int stall_cycles = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // One generator step: advance the state and permute the old one into a draw.
   function automatic logic [31:0] step_stream(int idx);
      logic [63:0] old;
      logic [31:0] xs;
      logic [4:0]  rot;
      old = pcg_state[idx];
      pcg_state[idx] = old * PCG_MULTIPLIER + pcg_inc[idx];
      xs = 32'(((old >> 18) ^ old) >> 27);
      rot = old[63:59];
      if (rot == 5'd0)
         return xs;
      return (xs >> rot) | (xs << (32 - int'(rot)));
   endfunction

   // Work out the result of one item and update the generator it selects.
   function automatic draw_rsp_t predict_draw(draw_req_t rq);
      draw_rsp_t          rs;
      int                 idx;
      logic signed [31:0] lo;
      logic signed [31:0] hi;
      logic [31:0]        span;
      logic [31:0]        thr;
      logic [31:0]        r;
      idx = int'(rq.stream) % N_PCG_STREAMS;
      rs.draw = '0;
      case (rq.opcode)
         OP_RAW: begin
            rs.draw = step_stream(idx);
         end
         OP_BOUNDED: begin
            lo = rq.lower;
            hi = rq.upper;
            // Reversed bounds are swapped before the span is formed.
            if (hi < lo) begin
               lo = rq.upper;
               hi = rq.lower;
            end
            span = $unsigned(hi) - $unsigned(lo) + 32'd1;
            if (span == 32'd0) begin
               // The span covers every 32-bit value, so any draw will do.
               rs.draw = step_stream(idx);
            end else begin
               thr = (32'd0 - span) % span;
               r = step_stream(idx);
               while (r < thr)
                  r = step_stream(idx);
               rs.draw = $unsigned(lo) + (r % span);
            end
         end
         OP_RESEED: begin
            pcg_state[idx] = '0;
            pcg_inc[idx] = {rq.seed[62:0], 1'b1};
            void'(step_stream(idx));
            pcg_state[idx] = pcg_state[idx] + PCG_SEED_STATE + rq.seed;
            void'(step_stream(idx));
         end
         OP_SET_LOW: begin
            pcg_state[idx] = {pcg_state[idx][63:52], rq.state_val};
         end
         default: begin
         end
      endcase
      rs.state_low = pcg_state[idx][51:0];
      return rs;
   endfunction

   function automatic draw_req_t make_req(op_type op, logic [3:0] stream, logic [31:0] lo,
                                          logic [31:0] hi, logic [63:0] seed,
                                          logic [51:0] sv);
      draw_req_t rq;
      rq.opcode = op;
      rq.stream = stream;
      rq.lower = lo;
      rq.upper = hi;
      rq.seed = seed;
      rq.state_val = sv;
      return rq;
   endfunction

   // Random item: every field random, bounded draws shaped towards interesting spans.
   function automatic draw_req_t random_req();
      draw_req_t   rq;
      int          pick;
      logic [31:0] tmp;
      rq.stream = 4'($urandom_range(0, 15));
      rq.lower = $urandom;
      rq.upper = $urandom;
      rq.seed = {$urandom, $urandom};
      rq.state_val = {20'($urandom), $urandom};
      pick = $urandom_range(0, 99);
      if (pick < 30)
         rq.opcode = OP_RAW;
      else if (pick < 75)
         rq.opcode = OP_BOUNDED;
      else if (pick < 85)
         rq.opcode = OP_RESEED;
      else
         rq.opcode = OP_SET_LOW;
      if (rq.opcode == OP_BOUNDED) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: rq.upper = rq.lower + 32'($urandom_range(0, 200));
            4: rq.upper = rq.lower - 32'($urandom_range(1, 200));
            5: rq.upper = rq.lower;
            6: begin
               // Span just over half the range: the rejection threshold is high.
               rq.lower = 32'd0 - 32'($urandom_range(1, 100));
               rq.upper = 32'h7fff_ffff - 32'($urandom_range(0, 100));
            end
            7: begin
               rq.lower = 32'h8000_0000 + 32'($urandom_range(0, 2));
               rq.upper = 32'h7fff_ffff - 32'($urandom_range(0, 2));
            end
            default: begin
            end
         endcase
         if ($urandom_range(0, 3) == 0) begin
            tmp = rq.lower;
            rq.lower = rq.upper;
            rq.upper = tmp;
         end
      end
      return rq;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50)
         return 0;
      if (r < 80)
         return $urandom_range(1, 6);
      if (r < 95)
         return $urandom_range(7, 60);
      return $urandom_range(61, 200);
   endfunction

   task automatic present_next();
      cur_req = pending_reqs.pop_front();
      start <= 1'b1;
      req_opcode <= cur_req.opcode;
      req_stream_index <= cur_req.stream;
      req_lower_bound <= cur_req.lower;
      req_upper_bound <= cur_req.upper;
      req_seed_value <= cur_req.seed;
      req_state_value <= cur_req.state_val;
   endtask

   // Driver: presents items from the pending queue, with random gaps and bursts.
   always @(posedge clock) begin
      int gap;
      if (!reset) begin
         if (start && !busy) begin
            expected_draws.push_back(predict_draw(cur_req));
            op_count[int'(cur_req.opcode)]++;
            n_accepted++;
            if (burst_left > 0) begin
               burst_left--;
               gap = 0;
            end else begin
               gap = pick_gap();
               if ($urandom_range(0, 15) == 0)
                  burst_left = $urandom_range(20, 60);
            end
            if (gap == 0 && pending_reqs.size() > 0) begin
               present_next();
            end else begin
               start <= 1'b0;
               gap_left = gap;
            end
         end else if (!start) begin
            if (gap_left > 0)
               gap_left--;
            else if (pending_reqs.size() > 0)
               present_next();
         end
      end
   end

   // Monitor: each result is checked against the oldest expectation.
   always @(posedge clock) begin
      draw_rsp_t want;
      if (!reset && rsp_valid) begin
         n_results++;
         if (expected_draws.size() == 0) begin
            $error("unexpected result: draw_value %h state_low %h",
                   rsp_draw_value, rsp_state_low);
            n_errors++;
         end else begin
            want = expected_draws.pop_front();
            if (rsp_draw_value !== want.draw) begin
               $error("draw_value: expected %h, got %h", want.draw, rsp_draw_value);
               n_errors++;
            end
            if (rsp_state_low !== want.state_low) begin
               $error("state_low: expected %h, got %h", want.state_low, rsp_state_low);
               n_errors++;
            end
         end
      end
   end

   // Watchdog: the run is stuck if neither an item nor a result moves for too long.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles == WATCHDOG_LIMIT) begin
            $display("watchdog expired after %0d idle cycles", WATCHDOG_LIMIT);
            $display("tb: failure");
            $finish;
         end
      end
   end

   initial begin
      int i;
      for (i = 0; i < N_PCG_STREAMS; i++) begin
         pcg_state[i] = PCG_SEED_STATE;
         pcg_inc[i] = PCG_SEED_INC;
      end

      // Directed items: stream extremes, span corner cases, reseed and set extremes.
      pending_reqs.push_back(make_req(OP_RAW, 4'd0, 32'd0, 32'd0, '0, '0));
      pending_reqs.push_back(make_req(OP_RAW, 4'd15, '1, '1, '1, '1));
      pending_reqs.push_back(make_req(OP_BOUNDED, 4'd0, 32'd0, 32'd0, '0, '0));
      pending_reqs.push_back(make_req(OP_BOUNDED, 4'd1, 32'h8000_0000, 32'h7fff_ffff,
                                      '0, '0));
      pending_reqs.push_back(make_req(OP_BOUNDED, 4'd1, 32'h7fff_ffff, 32'h8000_0000,
                                      '0, '0));
      pending_reqs.push_back(make_req(OP_BOUNDED, 4'd2, 32'd100, -32'sd100, '0, '0));
      pending_reqs.push_back(make_req(OP_BOUNDED, 4'd2, 32'h7fff_ffff, 32'h7fff_ffff,
                                      '0, '0));
      pending_reqs.push_back(make_req(OP_BOUNDED, 4'd2, 32'h8000_0000, 32'h8000_0000,
                                      '0, '0));
      pending_reqs.push_back(make_req(OP_BOUNDED, 4'd7, 32'd0, 32'h7fff_ffff, '0, '0));
      pending_reqs.push_back(make_req(OP_BOUNDED, 4'd7, '1, 32'h7fff_ffff, '0, '0));
      pending_reqs.push_back(make_req(OP_BOUNDED, 4'd8, 32'h8000_0000, 32'h7fff_fffe,
                                      '0, '0));
      pending_reqs.push_back(make_req(OP_BOUNDED, 4'd8, '1, 32'd0, '0, '0));
      pending_reqs.push_back(make_req(OP_RESEED, 4'd3, '0, '0, 64'd0, '0));
      pending_reqs.push_back(make_req(OP_RAW, 4'd3, '0, '0, '0, '0));
      pending_reqs.push_back(make_req(OP_RESEED, 4'd4, '1, '1, '1, '1));
      pending_reqs.push_back(make_req(OP_BOUNDED, 4'd4, -32'sd10, 32'd10, '0, '0));
      pending_reqs.push_back(make_req(OP_SET_LOW, 4'd5, '0, '0, '0, '0));
      pending_reqs.push_back(make_req(OP_RAW, 4'd5, '0, '0, '0, '0));
      pending_reqs.push_back(make_req(OP_SET_LOW, 4'd6, '0, '0, '0, '1));
      pending_reqs.push_back(make_req(OP_RAW, 4'd6, '0, '0, '0, '0));
      pending_reqs.push_back(make_req(OP_RESEED, 4'd15, '0, '0, 64'h8000_0000_0000_0000,
                                      '0));
      pending_reqs.push_back(make_req(OP_BOUNDED, 4'd15, 32'd1, 32'd6, '0, '0));

      for (i = 0; i < N_RANDOM; i++)
         pending_reqs.push_back(random_req());
      n_total = pending_reqs.size();

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      wait (n_accepted == n_total);
      wait (expected_draws.size() == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("covered %0d items over %0d streams: %0d raw, %0d bounded, %0d reseed, %0d set",
               n_accepted, N_PCG_STREAMS, op_count[int'(OP_RAW)],
               op_count[int'(OP_BOUNDED)], op_count[int'(OP_RESEED)],
               op_count[int'(OP_SET_LOW)]);
      $display("%0d results compared, %0d mismatches", n_results, n_errors);
      if (n_errors == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
